>>> rtl/core/tlcad_pkg.sv
package tlcad_pkg;

    localparam int MaxNodesDefault = 64;
    localparam int IdxW            = 6;
    localparam int CountW          = 7;
    localparam int LeafW           = 7;
    localparam int LeafMax         = 127;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // sequencer steps (micro-program addresses)
    typedef enum logic [3:0] {
        U_IDLE,
        U_CLR_RD,
        U_CLR_CHK,
        U_ROOT,
        U_MK_RD,
        U_MK_AL,
        U_MK_EV,
        U_CH_RD,
        U_CH_EV,
        U_LF_RD,
        U_LF_EV,
        U_DONE
    } t_ustep;

    // sequencing modes
    typedef enum logic [2:0] {
        J_NEXT,
        J_IDLE,
        J_LOOP,
        J_PASS,
        J_ROOT,
        J_EMIT
    } t_jump;

    typedef struct packed {
        logic   clear_wr;
        logic   root_scan;
        logic   root_set;
        logic   mark_eval;
        logic   child_eval;
        logic   leaf_eval;
        t_jump  jump;
        t_ustep target;
    } t_uword;

    typedef struct packed {
        logic            has_parent;
        logic [IdxW-1:0] parent;
    } t_pentry;

    // control store
    function automatic t_uword ucode(input t_ustep step);
        t_uword w;
        w        = '0;
        w.jump   = J_NEXT;
        w.target = U_IDLE;
        case (step)
            U_IDLE: begin
                w.jump = J_IDLE;
            end
            U_CLR_RD: begin
                w.clear_wr = 1'b1;
            end
            U_CLR_CHK: begin
                w.root_scan = 1'b1;
                w.jump      = J_LOOP;
                w.target    = U_CLR_RD;
            end
            U_ROOT: begin
                w.root_set = 1'b1;
                w.jump     = J_ROOT;
                w.target   = U_DONE;
            end
            U_MK_RD: begin
                w.jump = J_NEXT;
            end
            U_MK_AL: begin
                w.jump = J_NEXT;
            end
            U_MK_EV: begin
                w.mark_eval = 1'b1;
                w.jump      = J_PASS;
                w.target    = U_MK_RD;
            end
            U_CH_RD: begin
                w.jump = J_NEXT;
            end
            U_CH_EV: begin
                w.child_eval = 1'b1;
                w.jump       = J_LOOP;
                w.target     = U_CH_RD;
            end
            U_LF_RD: begin
                w.jump = J_NEXT;
            end
            U_LF_EV: begin
                w.leaf_eval = 1'b1;
                w.jump      = J_LOOP;
                w.target    = U_LF_RD;
            end
            U_DONE: begin
                w.jump   = J_EMIT;
                w.target = U_IDLE;
            end
            default: begin
                w.jump   = J_EMIT;
                w.target = U_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

>>> rtl/core/tlcad_in_if.sv
interface tlcad_in_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [tlcad_pkg::IdxW-1:0]    node_index;
    logic                          has_parent;
    logic [tlcad_pkg::IdxW-1:0]    parent_index;
    logic [tlcad_pkg::CountW-1:0]  node_count;
    logic [tlcad_pkg::IdxW-1:0]    delete_node;

    modport source (
        output valid, action, node_index, has_parent, parent_index, node_count, delete_node,
        input  ready
    );
    modport sink (
        input  valid, action, node_index, has_parent, parent_index, node_count, delete_node,
        output ready
    );
endinterface

>>> rtl/core/tlcad_out_if.sv
interface tlcad_out_if;
    logic                         valid;
    logic                         ready;
    logic [tlcad_pkg::LeafW-1:0]  leaf_count;

    modport source (
        output valid, leaf_count,
        input  ready
    );
    modport sink (
        input  valid, leaf_count,
        output ready
    );
endinterface

>>> rtl/core/tree_leaf_count_after_delete_unit.sv
// Leaf count after subtree removal.
// i_in carries two kinds of transfer. A load (action = load) writes one
// parent-table entry; loads are taken back to back.
// A query (action = query) gives a node count n and a node to delete and
// yields one transfer on o_res: the leaves left once that node's subtree
// is gone. Loads produce nothing on o_res.
// A query runs a micro-program over a single-ported parent table and two
// small mark memories, one node per step group:
//   clear + root scan, root check, marking passes, child marks, leaf count
//   and hand-off, in that order; a deleted root or n = 0 goes straight to
//   the hand-off. Marking passes repeat up to and including the first pass
//   that marks nothing new; their number is 2 plus the most links below the
//   root's children on one path whose parent has the higher index (1 when
//   nothing hangs below the root), so at most n.
// The marking pass rate is set by the table read followed by the mark read.
// i_in is ready only while the sequencer is idle; one query at a time.
// A finished count sits in an output register, so a new load or query is
// taken while o_res is stalled; a second query then waits at its hand-off.
// Reset (i_rst_n low, synchronous) idles the sequencer and empties the
// output register; the parent table keeps whatever it holds.
module tree_leaf_count_after_delete_unit #(
    parameter int MAX_NODES = tlcad_pkg::MaxNodesDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tlcad_in_if.sink    i_in,
    tlcad_out_if.source o_res
);

    localparam int AW = $clog2(MAX_NODES);
    localparam int NW = $clog2(MAX_NODES + 1);

    // storage
    tlcad_pkg::t_pentry r_ptab  [MAX_NODES];
    logic               r_alive [MAX_NODES];
    logic               r_hac   [MAX_NODES];

    // sequencer and datapath registers
    tlcad_pkg::t_ustep  r_step, n_step;
    logic [AW-1:0]      r_idx, n_idx;
    logic               r_changed, n_changed;
    logic [NW-1:0]      r_n;
    logic [tlcad_pkg::IdxW-1:0] r_del;
    logic [AW-1:0]      r_root;
    logic [NW-1:0]      r_cnt;
    tlcad_pkg::t_pentry r_tab_q;
    logic               r_alv_i;
    logic               r_alv_p;
    logic               r_hac_i;
    logic               r_out_valid;
    logic [tlcad_pkg::LeafW-1:0] r_out_leaf;

    tlcad_pkg::t_uword  uw;
    logic               in_fire;
    logic               query_fire;
    logic               load_fire;
    logic [NW-1:0]      n_sat;
    logic               idx_last;
    logic               par_in;
    logic               idx_is_del;
    logic               root_is_del;
    logic               mark_hit;
    logic               child_hit;
    logic               leaf_hit;
    logic               slot_free;
    logic               load_out;
    logic [tlcad_pkg::LeafW-1:0] leaf_sat;

    logic               alive_we, alive_wd;
    logic [AW-1:0]      alive_wa;
    logic               hac_we, hac_wd;
    logic [AW-1:0]      hac_wa;

    // current control word
    assign uw = tlcad_pkg::ucode(r_step);

    assign i_in.ready  = (r_step == tlcad_pkg::U_IDLE);
    assign in_fire     = i_in.valid && i_in.ready;
    assign query_fire  = in_fire && (i_in.action == tlcad_pkg::ACT_QUERY);
    assign load_fire   = in_fire && (i_in.action == tlcad_pkg::ACT_LOAD);

    // node count clamps to the table depth
    assign n_sat = (32'(i_in.node_count) > MAX_NODES) ? NW'(MAX_NODES)
                                                      : NW'(i_in.node_count);

    // per-node conditions
    assign idx_last    = (32'(r_idx) == 32'(r_n) - 32'd1);
    assign par_in      = (32'(r_tab_q.parent) < 32'(r_n));
    assign idx_is_del  = (32'(r_idx) == 32'(r_del));
    assign root_is_del = (32'(r_root) == 32'(r_del));

    // a node joins the survivors when its live parent is in range and it was
    // not the deleted node; already-live nodes don't count as a change
    assign mark_hit  = uw.mark_eval && !r_alv_i && !idx_is_del &&
                       r_tab_q.has_parent && par_in && r_alv_p;
    assign child_hit = uw.child_eval && r_alv_i && (r_idx != r_root) &&
                       r_tab_q.has_parent && par_in;
    assign leaf_hit  = uw.leaf_eval && r_alv_i && !r_hac_i;

    assign slot_free = !r_out_valid || o_res.ready;
    assign leaf_sat  = (32'(r_cnt) > tlcad_pkg::LeafMax) ? tlcad_pkg::LeafW'(tlcad_pkg::LeafMax)
                                                         : tlcad_pkg::LeafW'(r_cnt);

    // next step
    always_comb begin
        n_step    = r_step;
        n_idx     = r_idx;
        n_changed = r_changed | mark_hit;
        case (uw.jump)
            tlcad_pkg::J_IDLE: begin
                if (query_fire) begin
                    n_idx  = '0;
                    n_step = (n_sat == '0) ? tlcad_pkg::U_DONE : tlcad_pkg::U_CLR_RD;
                end
            end
            tlcad_pkg::J_NEXT: begin
                n_step = tlcad_pkg::t_ustep'(4'(r_step) + 4'd1);
            end
            tlcad_pkg::J_LOOP: begin
                if (idx_last) begin
                    n_idx  = '0;
                    n_step = tlcad_pkg::t_ustep'(4'(r_step) + 4'd1);
                end else begin
                    n_idx  = AW'(r_idx + 1'b1);
                    n_step = uw.target;
                end
            end
            tlcad_pkg::J_PASS: begin
                if (!idx_last) begin
                    n_idx  = AW'(r_idx + 1'b1);
                    n_step = uw.target;
                end else begin
                    n_idx = '0;
                    // rerun until a pass adds nobody
                    if (r_changed || mark_hit) begin
                        n_changed = 1'b0;
                        n_step    = uw.target;
                    end else begin
                        n_step = tlcad_pkg::t_ustep'(4'(r_step) + 4'd1);
                    end
                end
            end
            tlcad_pkg::J_ROOT: begin
                n_changed = 1'b0;
                if (root_is_del) begin
                    n_step = uw.target;
                end else begin
                    n_step = tlcad_pkg::t_ustep'(4'(r_step) + 4'd1);
                end
            end
            tlcad_pkg::J_EMIT: begin
                if (slot_free) begin
                    n_step = uw.target;
                end
            end
            default: begin
                n_step = tlcad_pkg::U_IDLE;
            end
        endcase
    end

    // datapath strobes
    always_comb begin
        alive_we = 1'b0;
        alive_wa = r_idx;
        alive_wd = 1'b0;
        hac_we   = 1'b0;
        hac_wa   = r_idx;
        hac_wd   = 1'b0;
        if (uw.clear_wr) begin
            alive_we = 1'b1;
            hac_we   = 1'b1;
        end
        if (uw.root_set && !root_is_del) begin
            alive_we = 1'b1;
            alive_wa = r_root;
            alive_wd = 1'b1;
        end
        if (mark_hit) begin
            alive_we = 1'b1;
            alive_wd = 1'b1;
        end
        if (child_hit) begin
            hac_we = 1'b1;
            hac_wa = AW'(r_tab_q.parent);
            hac_wd = 1'b1;
        end
    end

    assign load_out = (uw.jump == tlcad_pkg::J_EMIT) && slot_free;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= tlcad_pkg::U_IDLE;
            r_out_valid <= 1'b0;
            r_changed   <= 1'b0;
        end else begin
            r_step    <= n_step;
            r_changed <= n_changed;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (query_fire) begin
            r_n    <= n_sat;
            r_del  <= i_in.delete_node;
            r_root <= '0;
            r_cnt  <= '0;
        end else begin
            if (uw.root_scan && !r_tab_q.has_parent) begin
                r_root <= r_idx;
            end
            if (leaf_hit) begin
                r_cnt <= NW'(r_cnt + 1'b1);
            end
        end
        if (load_out) begin
            r_out_leaf <= leaf_sat;
        end
    end

    // memory reads, registered
    always_ff @(posedge i_clk) begin
        r_tab_q <= r_ptab[r_idx];
        r_alv_i <= r_alive[r_idx];
        r_alv_p <= r_alive[AW'(r_tab_q.parent)];
        r_hac_i <= r_hac[r_idx];
    end

    // memory writes
    always_ff @(posedge i_clk) begin
        if (load_fire && (32'(i_in.node_index) < MAX_NODES)) begin
            r_ptab[AW'(i_in.node_index)] <= '{has_parent: i_in.has_parent,
                                              parent:     i_in.parent_index};
        end
    end

    always_ff @(posedge i_clk) begin
        if (alive_we) begin
            r_alive[alive_wa] <= alive_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hac_we) begin
            r_hac[hac_wa] <= hac_wd;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.leaf_count = r_out_leaf;

    // checks
    a_query_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (query_fire && (n_sat != '0)) |=> (r_step == tlcad_pkg::U_CLR_RD))
        else $error("query did not start the clear sweep");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_step != tlcad_pkg::U_IDLE) && (r_step != tlcad_pkg::U_DONE))
            |-> (32'(r_idx) < 32'(r_n)))
        else $error("node index ran past the node count");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_step == tlcad_pkg::U_DONE) && !slot_free) |=> (r_step == tlcad_pkg::U_DONE))
        else $error("result hand-off left while output was full");

    a_leaf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (32'(r_out_leaf) <= MAX_NODES))
        else $error("leaf count above node capacity");

endmodule
